### design/pipt_pkg.sv
// Package for the power-invariant Park transform: widths, gains, sine coefficients
// and the transfer structs shared by the lanes, the merge stage and the top level.
// No dependencies.
package pipt_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int ANGLE_WIDTH  = 16;

  localparam int PHASE_WIDTH  = 32;  // angle placed as a 32-bit turn fraction
  localparam int FRAC_BITS    = 30;  // Q2.30 trig and gain grid
  localparam int QUART_WIDTH  = 31;  // folded angle and its square, 0 .. 2^30
  localparam int POLY_WIDTH   = 32;  // Horner accumulator
  localparam int TRIG_WIDTH   = 32;  // signed sine/cosine, -2^30 .. 2^30
  localparam int OPER_WIDTH   = 32;  // rotation operands
  localparam int GAIN_WIDTH   = 31;
  localparam int ACC_WIDTH    = 64;

  localparam int HORNER_STEPS = 6;
  localparam int SINE_LAT     = HORNER_STEPS + 4;
  localparam int PREP_LAT     = 3;
  localparam int MERGE_LAT    = 5;

  localparam logic [PHASE_WIDTH-1:0] PHASE_QUARTER = 32'h4000_0000;
  localparam logic [QUART_WIDTH-1:0] QUART_ONE     = 31'h4000_0000;

  typedef logic signed [POLY_WIDTH-1:0]   poly_t;
  typedef logic signed [TRIG_WIDTH-1:0]   trig_t;
  typedef logic signed [OPER_WIDTH-1:0]   oper_t;
  typedef logic signed [ACC_WIDTH-1:0]    acc_t;
  typedef logic signed [GAIN_WIDTH-1:0]   gain_t;
  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

  localparam trig_t TRIG_ONE = 32'sh4000_0000;

  // odd sine polynomial, Q30, lowest order first
  localparam poly_t SINE_COEF [HORNER_STEPS+1] = '{
    32'sd1686629713, -32'sd693598668, 32'sd85569306, -32'sd5026995,
    32'sd172272, -32'sd3864, 32'sd61
  };

  localparam gain_t GAIN_K  = 31'sd876706528;  // sqrt(2/3)
  localparam gain_t GAIN_KH = 31'sd438353264;  // sqrt(2/3)/2
  localparam gain_t GAIN_R  = 31'sd759250125;  // 1/sqrt(2)

  typedef enum logic {
    CMD_FORWARD = 1'b0,
    CMD_INVERSE = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t                   command;
    logic [ANGLE_WIDTH-1:0] angle;
    sample_t                in_first;
    sample_t                in_second;
    sample_t                in_third;
  } in_item_t;

  typedef struct packed {
    sample_t out_first;
    sample_t out_second;
    sample_t out_third;
  } out_item_t;

  // operands handed from the prep lane to the merge stage
  typedef struct packed {
    cmd_t  command;
    oper_t op_u;
    oper_t op_v;
  } rot_in_t;

endpackage

### design/pipt_sine_lane.sv
// One sine lane: quadrant fold, square, six Horner stages, final multiply, clamp.
// Depends on pipt_pkg.
module pipt_sine_lane (
  input  logic                             clk,
  input  logic                             en,
  input  logic [pipt_pkg::PHASE_WIDTH-1:0] phase,
  output pipt_pkg::trig_t                  sine
);

  localparam int QW = pipt_pkg::QUART_WIDTH;
  localparam int PW = pipt_pkg::POLY_WIDTH;
  localparam int FB = pipt_pkg::FRAC_BITS;
  localparam int NS = pipt_pkg::HORNER_STEPS;

  logic [QW-1:0]          fold_nxt;
  logic [QW-1:0]          x_r [NS+2];
  logic [QW-1:0]          x2_r [NS];
  logic                   neg_r [NS+3];
  logic [2*QW-1:0]        sq;
  pipt_pkg::poly_t        acc_in [NS];
  logic signed [2*PW-1:0] prod [NS];
  pipt_pkg::poly_t        poly_r [NS];
  logic signed [2*PW-1:0] fin_prod;
  pipt_pkg::poly_t        fin_r;
  pipt_pkg::trig_t        clamp_val;
  pipt_pkg::trig_t        sine_r;

  // odd quadrants run the quarter wave backwards
  always_comb begin
    fold_nxt = {1'b0, phase[FB-1:0]};
    if (phase[FB]) begin
      fold_nxt = pipt_pkg::QUART_ONE - {1'b0, phase[FB-1:0]};
    end
  end

  assign sq = x_r[0] * x_r[0];

  always_comb begin
    acc_in[0] = pipt_pkg::SINE_COEF[NS];
    for (int k = 1; k < NS; k++) begin
      acc_in[k] = poly_r[k-1];
    end
    for (int k = 0; k < NS; k++) begin
      prod[k] = acc_in[k] * $signed({1'b0, x2_r[k]});
    end
  end

  assign fin_prod = poly_r[NS-1] * $signed({1'b0, x_r[NS+1]});

  always_comb begin
    clamp_val = fin_r;
    if (fin_r < 0) begin
      clamp_val = '0;
    end else if (fin_r > pipt_pkg::TRIG_ONE) begin
      clamp_val = pipt_pkg::TRIG_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]   <= fold_nxt;
      neg_r[0] <= phase[FB+1];
      x_r[1]   <= x_r[0];
      x2_r[0]  <= sq[FB +: QW];
      for (int s = 2; s < NS + 2; s++) begin
        x_r[s] <= x_r[s-1];
      end
      for (int s = 1; s < NS + 3; s++) begin
        neg_r[s] <= neg_r[s-1];
      end
      for (int k = 1; k < NS; k++) begin
        x2_r[k] <= x2_r[k-1];
      end
      for (int k = 0; k < NS; k++) begin
        poly_r[k] <= pipt_pkg::SINE_COEF[NS-1-k] + prod[k][FB +: PW];
      end
      fin_r  <= fin_prod[FB +: PW];
      sine_r <= neg_r[NS+2] ? -clamp_val : clamp_val;
    end
  end

  assign sine = sine_r;

endmodule

### design/pipt_rot_prep.sv
// Prep lane: Clarke-style alpha/beta scaling for the forward command, operand
// select for the inverse, delayed to line up with the sine lanes. Depends on pipt_pkg.
module pipt_rot_prep (
  input  logic               clk,
  input  logic               en,
  input  pipt_pkg::in_item_t item,
  output pipt_pkg::rot_in_t  rot
);

  localparam int SW    = pipt_pkg::SAMPLE_WIDTH;
  localparam int GW    = pipt_pkg::GAIN_WIDTH;
  localparam int OW    = pipt_pkg::OPER_WIDTH;
  localparam int SUM_W = SW + 2;
  localparam int DIF_W = SW + 1;
  localparam int PRD_W = SUM_W + GW;
  localparam int DLY   = pipt_pkg::SINE_LAT - pipt_pkg::PREP_LAT;
  localparam logic [PRD_W:0] HALF = (PRD_W + 1)'(1) << (SW - 2);

  logic signed [SUM_W-1:0] sum_r;
  logic signed [DIF_W-1:0] dif_r;
  logic signed [PRD_W-1:0] pa_r;
  logic signed [PRD_W-1:0] pb_r;
  logic [PRD_W:0]          pa_rnd;
  logic [PRD_W:0]          pb_rnd;
  pipt_pkg::cmd_t          cmd_r [2];
  pipt_pkg::sample_t       first_r [2];
  pipt_pkg::sample_t       second_r [2];
  pipt_pkg::rot_in_t       rot_nxt;
  pipt_pkg::rot_in_t       rot_r;
  pipt_pkg::rot_in_t       dly_r [DLY];

  // round half up, then drop SW-1 fraction bits
  assign pa_rnd = {pa_r[PRD_W-1], pa_r} + HALF;
  assign pb_rnd = {pb_r[PRD_W-1], pb_r} + HALF;

  always_comb begin
    rot_nxt.command = cmd_r[1];
    if (cmd_r[1] == pipt_pkg::CMD_FORWARD) begin
      rot_nxt.op_u = pa_rnd[SW-1 +: OW];
      rot_nxt.op_v = pb_rnd[SW-1 +: OW];
    end else begin
      rot_nxt.op_u = pipt_pkg::oper_t'(first_r[1]);
      rot_nxt.op_v = pipt_pkg::oper_t'(second_r[1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r       <= (SUM_W'(item.in_first) <<< 1) - SUM_W'(item.in_second)
                     - SUM_W'(item.in_third);
      dif_r       <= DIF_W'(item.in_second) - DIF_W'(item.in_third);
      cmd_r[0]    <= item.command;
      first_r[0]  <= item.in_first;
      second_r[0] <= item.in_second;
      pa_r        <= sum_r * pipt_pkg::GAIN_KH;
      pb_r        <= dif_r * pipt_pkg::GAIN_R;
      cmd_r[1]    <= cmd_r[0];
      first_r[1]  <= first_r[0];
      second_r[1] <= second_r[0];
      rot_r       <= rot_nxt;
      dly_r[0]    <= rot_r;
      for (int i = 1; i < DLY; i++) begin
        dly_r[i] <= dly_r[i-1];
      end
    end
  end

  assign rot = dly_r[DLY-1];

endmodule

### design/pipt_rot_merge.sv
// Merge stage: combines the sine lane, cosine lane and prep lane into the rotated
// vector, applies the inverse gains, then rounds and saturates. Depends on pipt_pkg.
module pipt_rot_merge (
  input  logic                clk,
  input  logic                en,
  input  pipt_pkg::rot_in_t   rot,
  input  pipt_pkg::trig_t     sine,
  input  pipt_pkg::trig_t     cosine,
  output pipt_pkg::out_item_t result
);

  localparam int SW        = pipt_pkg::SAMPLE_WIDTH;
  localparam int AW        = pipt_pkg::ACC_WIDTH;
  localparam int NL        = pipt_pkg::MERGE_LAT;
  localparam int OUT_SHIFT = 2 * pipt_pkg::FRAC_BITS + 1 - SW;
  localparam pipt_pkg::acc_t MID_HALF = AW'(1) << (SW - 2);
  localparam pipt_pkg::acc_t OUT_HALF = AW'(1) << (OUT_SHIFT - 1);
  localparam pipt_pkg::sample_t S_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam pipt_pkg::sample_t S_MIN = {1'b1, {(SW-1){1'b0}}};

  pipt_pkg::cmd_t cmd_r [NL];
  pipt_pkg::acc_t ucs_r, vsn_r, vcs_r, usn_r;
  pipt_pkg::acc_t s0_r, s1_r;
  pipt_pkg::acc_t a0_r, a1_r;
  pipt_pkg::acc_t g0_r, g1_r, g2_r;
  pipt_pkg::acc_t c0_r, c1_r, c2_r;

  function automatic pipt_pkg::sample_t to_sample(input pipt_pkg::acc_t v);
    pipt_pkg::acc_t r;
    r = (v + OUT_HALF) >>> OUT_SHIFT;
    if (r > pipt_pkg::acc_t'(S_MAX)) begin
      return S_MAX;
    end
    if (r < pipt_pkg::acc_t'(S_MIN)) begin
      return S_MIN;
    end
    return r[SW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      cmd_r[0] <= rot.command;
      for (int i = 1; i < NL; i++) begin
        cmd_r[i] <= cmd_r[i-1];
      end

      // four rotation products
      ucs_r <= rot.op_u * cosine;
      vsn_r <= rot.op_v * sine;
      vcs_r <= rot.op_v * cosine;
      usn_r <= rot.op_u * sine;

      if (cmd_r[0] == pipt_pkg::CMD_FORWARD) begin
        s0_r <= ucs_r + vsn_r;
        s1_r <= vcs_r - usn_r;
      end else begin
        s0_r <= ucs_r - vsn_r;
        s1_r <= usn_r + vcs_r;
      end

      // inverse rounds alpha/beta back to the Q30 grid
      if (cmd_r[1] == pipt_pkg::CMD_FORWARD) begin
        a0_r <= s0_r;
        a1_r <= s1_r;
      end else begin
        a0_r <= (s0_r + MID_HALF) >>> (SW - 1);
        a1_r <= (s1_r + MID_HALF) >>> (SW - 1);
      end

      if (cmd_r[2] == pipt_pkg::CMD_FORWARD) begin
        g0_r <= a0_r;
        g1_r <= a1_r;
        g2_r <= '0;
      end else begin
        g0_r <= pipt_pkg::oper_t'(a0_r) * pipt_pkg::GAIN_K;
        g1_r <= pipt_pkg::oper_t'(a1_r) * pipt_pkg::GAIN_R;
        g2_r <= pipt_pkg::oper_t'(a0_r) * pipt_pkg::GAIN_KH;
      end

      if (cmd_r[3] == pipt_pkg::CMD_FORWARD) begin
        c0_r <= g0_r;
        c1_r <= g1_r;
        c2_r <= '0;
      end else begin
        c0_r <= g0_r;
        c1_r <= g1_r - g2_r;
        c2_r <= -g2_r - g1_r;
      end
    end
  end

  always_comb begin
    result.out_first  = to_sample(c0_r);
    result.out_second = to_sample(c1_r);
    result.out_third  = (cmd_r[NL-1] == pipt_pkg::CMD_FORWARD) ? '0 : to_sample(c2_r);
  end

endmodule

### design/power_invariant_park_transform.sv
// Power-invariant Park (dq) transform top level, forward abc->dq and inverse dq->abc.
// Uses pipt_pkg, two pipt_sine_lane copies, pipt_rot_prep and pipt_rot_merge.
// Pipeline: 15 stages from the input transfer, followed by the output register
//   that drives out_valid; the sine lane accounts for most of the stages.
// Throughput: one transfer per clock; the pipeline freezes only while the
//   two-entry output buffer is full.
// Reset: synchronous, active low; clears stage valids and the output buffer.
module power_invariant_park_transform (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pipt_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output pipt_pkg::out_item_t out_data
);

  localparam int PHW   = pipt_pkg::PHASE_WIDTH;
  localparam int TOTAL = pipt_pkg::SINE_LAT + pipt_pkg::MERGE_LAT;

  // Pipeline advance. Everything from the lanes through the merge stage moves
  // together; the output buffer absorbs one result while the head is stalled.
  logic en;
  logic accept;
  logic push;
  logic pop;

  logic [TOTAL-1:0] valid_r;

  logic [PHW-1:0]      phase_sin;
  logic [PHW-1:0]      phase_cos;
  pipt_pkg::trig_t     sin_val;
  pipt_pkg::trig_t     cos_val;
  pipt_pkg::rot_in_t   rot_ops;
  pipt_pkg::out_item_t merged;

  // output buffer: head drives the port, skid catches one extra transfer
  pipt_pkg::out_item_t head_r, head_nxt;
  pipt_pkg::out_item_t skid_r, skid_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                skid_valid_r, skid_valid_nxt;

  assign en       = !skid_valid_r;
  assign in_stall = skid_valid_r;
  assign accept   = in_valid && en;
  assign push     = en && valid_r[TOTAL-1];
  assign pop      = out_valid_r && !out_stall;

  // angle as a fraction of a full turn; cosine is a quarter turn ahead
  assign phase_sin = PHW'(in_data.angle) << (PHW - pipt_pkg::ANGLE_WIDTH);
  assign phase_cos = phase_sin + pipt_pkg::PHASE_QUARTER;

  pipt_sine_lane u_sin_lane (
    .clk   (clk),
    .en    (en),
    .phase (phase_sin),
    .sine  (sin_val)
  );

  pipt_sine_lane u_cos_lane (
    .clk   (clk),
    .en    (en),
    .phase (phase_cos),
    .sine  (cos_val)
  );

  // alpha/beta (forward) or d/q (inverse), aligned with the trig lanes
  pipt_rot_prep u_prep (
    .clk  (clk),
    .en   (en),
    .item (in_data),
    .rot  (rot_ops)
  );

  pipt_rot_merge u_merge (
    .clk    (clk),
    .en     (en),
    .rot    (rot_ops),
    .sine   (sin_val),
    .cosine (cos_val),
    .result (merged)
  );

  // Stage valids travel beside the datapath; data registers hold no reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[TOTAL-2:0], accept};
    end
  end

  always_comb begin
    head_nxt       = head_r;
    skid_nxt       = skid_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (skid_valid_r) begin
      // pipeline frozen; drain skid into head on a transfer
      if (pop) begin
        head_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        head_nxt      = merged;
        out_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = merged;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = head_r;

endmodule

### tb/testbench.sv
// Self-checking testbench for power_invariant_park_transform (forward and inverse dq0).
// Needs pipt_pkg and the top level; computes expected vectors with its own
// fixed-point rotation model.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transfer
  localparam int LONG_HOLD      = 200;   // receiver hold-off under pressure
  localparam int DRAIN_TAIL     = 40;    // longer than the pipeline latency
  localparam int OUT_SHIFT      = 61 - pipt_pkg::SAMPLE_WIDTH;  // Q60 product to sample grid
  localparam int IN_SHIFT       = pipt_pkg::SAMPLE_WIDTH - 1;   // back to Q30 intermediates
  localparam longint SAT_HI     = (longint'(1) <<< (pipt_pkg::SAMPLE_WIDTH - 1)) - 1;
  localparam longint SAT_LO     = -(longint'(1) <<< (pipt_pkg::SAMPLE_WIDTH - 1));

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  pipt_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  pipt_pkg::out_item_t out_data;

  // stimulus waiting for the driver, and vectors the block owes us
  pipt_pkg::in_item_t  vector_queue[$];
  pipt_pkg::out_item_t predicted_outputs[$];
  pipt_pkg::out_item_t oldest_dq;

  // knobs set by the sequencer on the falling edge, read on the rising edge
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  bit          sender_hold = 1'b0;
  int          hold_requests = 0;
  int          hold_served = 0;
  int          hold_left = 0;

  int          mismatches = 0;
  int          results_checked = 0;
  int          forward_count = 0;
  int          inverse_count = 0;
  int          blocked_offers = 0;
  int          idle_cycles = 0;

  power_invariant_park_transform uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Sine of a 32-bit turn fraction in Q30: fold into the first quadrant,
  // degree-13 odd polynomial by Horner with flooring shifts, clamp to [0, 1].
  function automatic longint turn_sine(logic [pipt_pkg::PHASE_WIDTH-1:0] ph);
    longint x;
    longint x_sq;
    longint acc;
    int     k;
    x = longint'(ph[29:0]);
    if (ph[30]) begin
      x = longint'(pipt_pkg::TRIG_ONE) - x;
    end
    x_sq = (x * x) >>> pipt_pkg::FRAC_BITS;
    acc = longint'(pipt_pkg::SINE_COEF[pipt_pkg::HORNER_STEPS]);
    for (k = pipt_pkg::HORNER_STEPS - 1; k >= 0; k--) begin
      acc = longint'(pipt_pkg::SINE_COEF[k]) + ((acc * x_sq) >>> pipt_pkg::FRAC_BITS);
    end
    acc = (acc * x) >>> pipt_pkg::FRAC_BITS;
    if (acc < 0) begin
      acc = 0;
    end
    if (acc > longint'(pipt_pkg::TRIG_ONE)) begin
      acc = longint'(pipt_pkg::TRIG_ONE);
    end
    return ph[31] ? -acc : acc;
  endfunction

  // round half up from the Q(30+15) product back to Q30
  function automatic longint round_to_q30(longint v);
    return (v + (longint'(1) <<< (IN_SHIFT - 1))) >>> IN_SHIFT;
  endfunction

  // round half up to the sample grid and saturate
  function automatic pipt_pkg::sample_t to_sample(longint v);
    longint r;
    r = (v + (longint'(1) <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
    if (r > SAT_HI) begin
      r = SAT_HI;
    end
    if (r < SAT_LO) begin
      r = SAT_LO;
    end
    return pipt_pkg::sample_t'(r);
  endfunction

  function automatic pipt_pkg::out_item_t park_predict(pipt_pkg::in_item_t v);
    logic [pipt_pkg::PHASE_WIDTH-1:0] ph;
    logic [pipt_pkg::PHASE_WIDTH-1:0] ph_cos;
    longint              sn, cs, a, b, c, alpha, beta, gk, gkh, gr;
    pipt_pkg::out_item_t r;
    ph = {v.angle, {(pipt_pkg::PHASE_WIDTH - pipt_pkg::ANGLE_WIDTH){1'b0}}};
    ph_cos = ph + pipt_pkg::PHASE_QUARTER;
    sn = turn_sine(ph);
    cs = turn_sine(ph_cos);
    gk = longint'(pipt_pkg::GAIN_K);
    gkh = longint'(pipt_pkg::GAIN_KH);
    gr = longint'(pipt_pkg::GAIN_R);
    a = longint'(v.in_first);
    b = longint'(v.in_second);
    c = longint'(v.in_third);
    if (v.command == pipt_pkg::CMD_FORWARD) begin
      alpha = round_to_q30((2 * a - b - c) * gkh);
      beta = round_to_q30((b - c) * gr);
      r.out_first = to_sample(alpha * cs + beta * sn);
      r.out_second = to_sample(beta * cs - alpha * sn);
      r.out_third = '0;
    end else begin
      // phase c input plays no part in the inverse
      alpha = round_to_q30(a * cs - b * sn);
      beta = round_to_q30(a * sn + b * cs);
      r.out_first = to_sample(gk * alpha);
      r.out_second = to_sample(gr * beta - gkh * alpha);
      r.out_third = to_sample(-gkh * alpha - gr * beta);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic pipt_pkg::in_item_t make_vector(
    pipt_pkg::cmd_t cmd, logic [pipt_pkg::ANGLE_WIDTH-1:0] ang,
    int x1, int x2, int x3);
    pipt_pkg::in_item_t v;
    v.command = cmd;
    v.angle = ang;
    v.in_first = pipt_pkg::sample_t'(x1);
    v.in_second = pipt_pkg::sample_t'(x2);
    v.in_third = pipt_pkg::sample_t'(x3);
    return v;
  endfunction

  task automatic add_vector(input pipt_pkg::in_item_t v);
    vector_queue.insert(vector_queue.size(), v);
  endtask

  // full-scale values show up often so saturation gets hit regularly
  function automatic pipt_pkg::sample_t random_sample();
    case ($urandom_range(9))
      0: return pipt_pkg::sample_t'(SAT_HI);
      1: return pipt_pkg::sample_t'(SAT_LO);
      default: return pipt_pkg::sample_t'($urandom());
    endcase
  endfunction

  // a fifth of the angles sit right on or next to a quadrant boundary
  function automatic logic [pipt_pkg::ANGLE_WIDTH-1:0] random_angle();
    if ($urandom_range(4) == 0) begin
      return pipt_pkg::ANGLE_WIDTH'($urandom_range(3) << (pipt_pkg::ANGLE_WIDTH - 2))
             + pipt_pkg::ANGLE_WIDTH'($urandom_range(4)) - pipt_pkg::ANGLE_WIDTH'(2);
    end
    return pipt_pkg::ANGLE_WIDTH'($urandom());
  endfunction

  function automatic pipt_pkg::in_item_t random_vector();
    pipt_pkg::in_item_t v;
    pipt_pkg::sample_t  x1, x2;
    v.command = pipt_pkg::cmd_t'($urandom_range(1));
    v.angle = random_angle();
    if (v.command == pipt_pkg::CMD_FORWARD && $urandom_range(9) < 3) begin
      // balanced three-phase set, the normal operating case
      x1 = pipt_pkg::sample_t'($urandom_range(32767)) - pipt_pkg::sample_t'(16384);
      x2 = pipt_pkg::sample_t'($urandom_range(32767)) - pipt_pkg::sample_t'(16384);
      v.in_first = x1;
      v.in_second = x2;
      v.in_third = -(x1 + x2);
    end else begin
      v.in_first = random_sample();
      v.in_second = random_sample();
      v.in_third = random_sample();
    end
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: once the current vector transferred or nothing is on the bus, offers the
  // next queued one unless held or idling at random. Payload stays put while stalled.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        // transfer at this edge: the block now owes us one vector
        predicted_outputs.insert(predicted_outputs.size(), park_predict(in_data));
        if (in_data.command == pipt_pkg::CMD_FORWARD) begin
          forward_count++;
        end else begin
          inverse_count++;
        end
      end
      if (vector_queue.size() != 0 && !sender_hold &&
          $urandom_range(99) >= send_idle_pct) begin
        in_data <= vector_queue.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end else begin
      blocked_offers++;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver back-pressure: random stalls, plus a long hold-off counted here
  // whenever the sequencer asks for one.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_served <= 0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      out_stall <= 1'b1;
      hold_left <= LONG_HOLD - 1;
      hold_served <= hold_requests;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every result transfer is matched against the oldest prediction.
  // ---------------------------------------------------------------------------
  task automatic compare_sample(input string label, input pipt_pkg::sample_t want,
                                input pipt_pkg::sample_t got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, got %0d", $time, label, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (predicted_outputs.size() == 0) begin
        $display("%0t: expected no result transfer, got %0d %0d %0d",
                 $time, out_data.out_first, out_data.out_second, out_data.out_third);
        mismatches++;
      end else begin
        oldest_dq = predicted_outputs.pop_front();
        compare_sample("out_first", oldest_dq.out_first, out_data.out_first);
        compare_sample("out_second", oldest_dq.out_second, out_data.out_second);
        compare_sample("out_third", oldest_dq.out_third, out_data.out_third);
        results_checked++;
      end
    end
  end

  // Watchdog: a stretch with no transfer on either side means the block hung.
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $time, WATCHDOG_LIMIT, predicted_outputs.size());
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------

  // wait until every queued vector has transferred and every result is back
  task automatic drain();
    while (vector_queue.size() != 0 || in_valid || predicted_outputs.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic queue_random(input int count);
    repeat (count) add_vector(random_vector());
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    @(negedge clk);
    send_idle_pct = send_pct;
    stall_pct = recv_pct;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: extremes, all four quadrant boundaries, saturation both ways,
    // zero third output on forward, phase c ignored on inverse.
    add_vector(make_vector(pipt_pkg::CMD_FORWARD, 16'h0000, 32767, -32768, -32768));
    add_vector(make_vector(pipt_pkg::CMD_FORWARD, 16'h0000, -32768, 32767, 32767));
    add_vector(make_vector(pipt_pkg::CMD_FORWARD, 16'h0000, 0, 0, 0));
    add_vector(make_vector(pipt_pkg::CMD_FORWARD, 16'h4000, 20000, -10000, -10000));
    add_vector(make_vector(pipt_pkg::CMD_FORWARD, 16'h8000, -32768, -32768, -32768));
    add_vector(make_vector(pipt_pkg::CMD_FORWARD, 16'hC000, 32767, 32767, 32767));
    add_vector(make_vector(pipt_pkg::CMD_FORWARD, 16'hFFFF, 12345, -23456, 11111));
    add_vector(make_vector(pipt_pkg::CMD_FORWARD, 16'h0001, -1, -1, 2));
    add_vector(make_vector(pipt_pkg::CMD_FORWARD, 16'h3FFF, 32767, 0, -32768));
    add_vector(make_vector(pipt_pkg::CMD_FORWARD, 16'h2AAB, 16384, -8192, -8192));
    add_vector(make_vector(pipt_pkg::CMD_FORWARD, 16'h8001, 32767, -32768, 0));
    add_vector(make_vector(pipt_pkg::CMD_INVERSE, 16'h0000, 32767, 0, 0));
    add_vector(make_vector(pipt_pkg::CMD_INVERSE, 16'h0000, -32768, 0, 0));
    add_vector(make_vector(pipt_pkg::CMD_INVERSE, 16'h2000, 32767, -32768, 0));
    add_vector(make_vector(pipt_pkg::CMD_INVERSE, 16'h2000, 32767, -32768, -32768));
    add_vector(make_vector(pipt_pkg::CMD_INVERSE, 16'h6000, -32768, -32768, 32767));
    add_vector(make_vector(pipt_pkg::CMD_INVERSE, 16'h8000, 0, 32767, -1));
    add_vector(make_vector(pipt_pkg::CMD_INVERSE, 16'hC001, 12000, -20000, 5));
    add_vector(make_vector(pipt_pkg::CMD_INVERSE, 16'hFFFF, 32767, 32767, 0));
    add_vector(make_vector(pipt_pkg::CMD_INVERSE, 16'h7FFF, -1, 1, 0));
    add_vector(make_vector(pipt_pkg::CMD_INVERSE, 16'hBFFF, 1000, -1000, 0));
    add_vector(make_vector(pipt_pkg::CMD_INVERSE, 16'h4000, 0, 0, 0));
    drain();

    // Random phases: full rate, sparse sender, heavy back-pressure, both light.
    queue_random(400);
    drain();
    set_idling(80, 0);
    queue_random(350);
    drain();
    set_idling(0, 80);
    queue_random(350);
    drain();
    set_idling(23, 23);
    queue_random(350);
    drain();

    // Long receiver hold-off while the sender keeps offering at full rate:
    // the pipeline and output buffer fill and in_stall must rise.
    set_idling(0, 0);
    queue_random(100);
    hold_requests++;
    while (hold_served != hold_requests || hold_left != 0) begin
      @(negedge clk);
    end
    drain();

    // Sender pauses mid-stream until everything in flight has come back.
    queue_random(60);
    while (vector_queue.size() > 30) begin
      @(negedge clk);
    end
    sender_hold = 1'b1;
    while (in_valid || predicted_outputs.size() != 0) begin
      @(negedge clk);
    end
    sender_hold = 1'b0;
    drain();

    // closing mix with light idling on both sides
    set_idling(23, 23);
    queue_random(270);
    drain();

    // let any stray result surface before the verdict
    repeat (DRAIN_TAIL) @(negedge clk);

    $display("Checked %0d results from %0d forward and %0d inverse transfers,",
             results_checked, forward_count, inverse_count);
    $display("including directed extremes, idling phases and %0d back-pressured offers.",
             blocked_offers);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
